@@ src/pds_pkg.sv @@
// Shared types and constants of the postings delta serializer.
`timescale 1ns / 1ps

package pds_pkg;

	localparam int WordW  = 32;
	localparam int CountW = 5;
	localparam int FifoDepth = 2;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_TRIPLE = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_ID_ORDER   = 3'd1,
		ERR_BAD_COUNT  = 3'd2,
		ERR_LOC_ORDER  = 3'd3,
		ERR_TIME_DEC   = 3'd4,
		ERR_LIMIT      = 3'd5,
		ERR_UNEXPECTED = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		ENT_WORD   = 2'd0,
		ENT_HEADER = 2'd1,
		ENT_DRAIN  = 2'd2
	} ent_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_COUNT = 2'd1,
		BK_TIME  = 2'd2,
		BK_ERR   = 2'd3
	} back_state_t;

	// One queued job: every accepted item that has results becomes one entry.
	typedef struct packed {
		ent_kind_t         kind;
		logic [WordW-1:0]  word;
		logic              last;
		err_t              code;
		logic [CountW-1:0] count;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [CountW-1:0] addr;
		logic [WordW-1:0]  time_val;
		logic [WordW-1:0]  err_val;
	} buf_wr_t;

	typedef struct packed {
		logic drain_done;
		logic draining;
	} back_stat_t;

	localparam logic REG_DELTA_MODE = 1'b0;
	localparam logic REG_MAX_ERROR  = 1'b1;

endpackage

@@ src/pds_if.sv @@
// Valid/ready channel interfaces for input items and result words.
`timescale 1ns / 1ps

interface pds_in_if import pds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [WordW-1:0]  doc_id;
	logic [CountW-1:0] term_count;
	logic [WordW-1:0]  location;
	logic [WordW-1:0]  time_value;
	logic [WordW-1:0]  quant_error;

	modport source (output valid, command, doc_id, term_count, location, time_value,
		quant_error, input ready);
	modport sink (input valid, command, doc_id, term_count, location, time_value,
		quant_error, output ready);
endinterface

interface pds_out_if import pds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WordW-1:0] word;
	logic             last;
	logic [2:0]       error_code;

	modport source (output valid, word, last, error_code, input ready);
	modport sink (input valid, word, last, error_code, output ready);
endinterface

@@ src/pds_front.sv @@
// Front end: accepts items, runs the order checks and queues one job per item but a start.
`timescale 1ns / 1ps

module pds_front import pds_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	pds_in_if.sink           item,
	input  logic             delta_mode,
	input  logic [WordW-1:0] max_error,
	input  logic             fifo_full,
	output logic             push,
	output entry_t           push_data,
	output buf_wr_t          buf_wr,
	input  back_stat_t       back_stat
);

	logic [WordW-1:0]  prev_id_q, prev_loc_q, prev_time_q;
	logic [WordW-1:0]  prev_id_d, prev_loc_d, prev_time_d;
	logic [CountW-1:0] pending_q, tidx_q, pending_d, tidx_d, tidx_inc;
	logic              wait_q, wait_set;
	logic              accept, count_ok, index_ok, first_raw, finished;
	cmd_t              cmd;
	err_t              hdr_code, trp_code;

	// After the last triple of a posting the buffers belong to the drain until it ends.
	assign item.ready = !fifo_full && !wait_q;
	assign accept     = item.valid && item.ready;
	assign cmd        = cmd_t'(item.command);

	assign count_ok  = (item.term_count != '0) && (item.term_count <= CountW'(MAX_TERMS));
	assign index_ok  = (tidx_q < pending_q) && (tidx_q < CountW'(MAX_TERMS));
	assign first_raw = (tidx_q == '0) || !delta_mode;
	assign tidx_inc  = tidx_q + CountW'(1);
	assign finished  = (tidx_inc == pending_q);

	always_comb begin
		if (tidx_q < pending_q) begin
			hdr_code = ERR_UNEXPECTED;
		end else if (item.doc_id <= prev_id_q) begin
			hdr_code = ERR_ID_ORDER;
		end else if (!count_ok) begin
			hdr_code = ERR_BAD_COUNT;
		end else begin
			hdr_code = ERR_OK;
		end

		if (first_raw) begin
			trp_code = ERR_OK;
		end else if (item.location <= prev_loc_q) begin
			trp_code = ERR_LOC_ORDER;
		end else if (item.time_value < prev_time_q) begin
			trp_code = ERR_TIME_DEC;
		end else if (item.quant_error > max_error) begin
			trp_code = ERR_LIMIT;
		end else begin
			trp_code = ERR_OK;
		end
	end

	always_comb begin
		prev_id_d   = prev_id_q;
		prev_loc_d  = prev_loc_q;
		prev_time_d = prev_time_q;
		pending_d   = pending_q;
		tidx_d      = tidx_q;
		wait_set    = 1'b0;
		push        = 1'b0;
		push_data.kind  = ENT_WORD;
		push_data.word  = '0;
		push_data.last  = 1'b1;
		push_data.code  = ERR_UNEXPECTED;
		push_data.count = '0;
		buf_wr.en       = 1'b0;
		buf_wr.addr     = tidx_q;
		buf_wr.time_val = first_raw ? item.time_value : item.time_value - prev_time_q;
		buf_wr.err_val  = item.quant_error;

		case (cmd)
			CMD_START: begin
				prev_id_d = item.doc_id;
				pending_d = '0;
				tidx_d    = '0;
			end
			CMD_HEADER: begin
				push            = accept;
				push_data.kind  = ENT_HEADER;
				push_data.word  = item.doc_id - prev_id_q;
				push_data.last  = 1'b0;
				push_data.code  = hdr_code;
				push_data.count = item.term_count;
				pending_d = count_ok ? item.term_count : '0;
				tidx_d    = '0;
				prev_id_d = delta_mode ? item.doc_id : '0;
			end
			CMD_TRIPLE: begin
				push = accept;
				if (!index_ok) begin
					push_data.word = item.location;
				end else begin
					// The location word of an accepted triple never closes the item.
					buf_wr.en      = accept;
					push_data.word = first_raw ? item.location : item.location - prev_loc_q;
					push_data.last = 1'b0;
					push_data.code = trp_code;
					prev_loc_d     = item.location;
					prev_time_d    = item.time_value;
					if (finished) begin
						push_data.kind  = ENT_DRAIN;
						push_data.count = pending_q;
						pending_d = '0;
						tidx_d    = '0;
						wait_set  = accept;
					end else begin
						tidx_d = tidx_inc;
					end
				end
			end
			default: begin
				push = accept;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_id_q   <= '0;
			prev_loc_q  <= '0;
			prev_time_q <= '0;
			pending_q   <= '0;
			tidx_q      <= '0;
			wait_q      <= 1'b0;
		end else begin
			if (accept) begin
				prev_id_q   <= prev_id_d;
				prev_loc_q  <= prev_loc_d;
				prev_time_q <= prev_time_d;
				pending_q   <= pending_d;
				tidx_q      <= tidx_d;
			end
			if (wait_set) begin
				wait_q <= 1'b1;
			end else if (back_stat.drain_done) begin
				wait_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/pds_fifo.sv @@
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module pds_fifo import pds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
	localparam int CntW = $clog2(FifoDepth + 1);

	entry_t          entries_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(FifoDepth));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

@@ src/pds_back.sv @@
// Back end: emits queued words; drains time/error buffers one word/cycle if ready.
`timescale 1ns / 1ps

module pds_back import pds_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fifo_empty,
	input  entry_t     pop_data,
	output logic       pop,
	input  buf_wr_t    buf_wr,
	output back_stat_t stat,
	pds_out_if.source  result
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	logic [WordW-1:0]  time_mem [MAX_TERMS];
	logic [WordW-1:0]  err_mem  [MAX_TERMS];
	logic [WordW-1:0]  time_rd_q, err_rd_q;

	back_state_t       state_q, state_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic [CountW-1:0] cnt_q, cnt_d;
	err_t              code_q, code_d;
	logic              idx_last, ld, out_ld;

	logic              out_valid_q, out_last_q, out_last_d;
	logic [WordW-1:0]  out_word_q, out_word_d;
	err_t              out_code_q, out_code_d;

	assign ld       = !out_valid_q || result.ready;
	assign idx_last = (CountW'(idx_q) + CountW'(1)) == cnt_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		code_d     = code_q;
		pop        = 1'b0;
		out_ld     = 1'b0;
		out_word_d = pop_data.word;
		out_last_d = 1'b0;
		out_code_d = ERR_OK;
		stat.drain_done = 1'b0;
		stat.draining   = (state_q == BK_TIME) || (state_q == BK_ERR);

		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty && ld) begin
					pop        = 1'b1;
					out_ld     = 1'b1;
					out_code_d = pop_data.code;
					code_d     = pop_data.code;
					cnt_d      = pop_data.count;
					idx_d      = '0;
					case (pop_data.kind)
						ENT_HEADER: state_d = BK_COUNT;
						ENT_DRAIN:  state_d = BK_TIME;
						default:    out_last_d = pop_data.last;
					endcase
				end
			end
			BK_COUNT: begin
				if (ld) begin
					out_ld     = 1'b1;
					out_word_d = WordW'(cnt_q);
					out_last_d = 1'b1;
					out_code_d = code_q;
					state_d    = BK_IDLE;
				end
			end
			BK_TIME: begin
				if (ld) begin
					out_ld     = 1'b1;
					out_word_d = time_rd_q;
					if (idx_last) begin
						idx_d   = '0;
						state_d = BK_ERR;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end
			end
			BK_ERR: begin
				if (ld) begin
					out_ld     = 1'b1;
					out_word_d = err_rd_q;
					out_last_d = idx_last;
					if (idx_last) begin
						idx_d   = '0;
						state_d = BK_IDLE;
						stat.drain_done = 1'b1;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// The read address follows the next index, so the registered data always
	// matches the current index.
	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			time_mem[buf_wr.addr[IW-1:0]] <= buf_wr.time_val;
			err_mem[buf_wr.addr[IW-1:0]]  <= buf_wr.err_val;
		end
		time_rd_q <= time_mem[idx_d];
		err_rd_q  <= err_mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (ld) begin
				out_valid_q <= out_ld;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		code_q <= code_d;
		if (out_ld) begin
			out_word_q <= out_word_d;
			out_last_q <= out_last_d;
			out_code_q <= out_code_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.word       = out_word_q;
	assign result.last       = out_last_q;
	assign result.error_code = out_code_q;

endmodule

@@ src/postings_delta_serializer_unit.sv @@
// Postings delta serializer: input and result channels, register port and job queue.
// Items enter on the item channel (valid/ready): start, posting header or payload
// triple. Results leave on the result channel, one 32-bit word per transfer, with
// an error code per word. last marks the count word of a header, the final error
// word of a drain and the word of a rejected item; other triples carry none.
// Registers sit on an APB-style port: delta_mode at 0x0, max_error at 0x4.
// The first word of an item is registered in the job queue, then in the result
// register. That register sends one word per cycle while the receiver is ready;
// a header yields two words, a triple one, a start none, and the last triple of
// a posting 1 + 2 * term_count words. The front end accepts one item per cycle
// while the two-entry job queue has room; after the last triple of a posting it
// accepts nothing until the back end has drained the time and error buffers.
// Reset clears the running ids, the counters and both channels; the buffers are
// only read after the same posting has written them.
// When the receiver stalls, the current word holds, the queue fills and then
// item ready drops.
`timescale 1ns / 1ps

module postings_delta_serializer_unit import pds_pkg::*; #(
	parameter int MAX_TERMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pds_in_if.sink      item,
	pds_out_if.source   result
);

	logic             delta_mode_q;
	logic [WordW-1:0] max_error_q;

	logic       fifo_push, fifo_pop, fifo_full, fifo_empty;
	entry_t     push_data, pop_data;
	buf_wr_t    buf_wr;
	back_stat_t back_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_mode_q <= 1'b1;
			max_error_q  <= '1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DELTA_MODE: delta_mode_q <= pwdata[0];
				REG_MAX_ERROR:  max_error_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DELTA_MODE: prdata = {31'd0, delta_mode_q};
			REG_MAX_ERROR:  prdata = max_error_q;
			default:        prdata = '0;
		endcase
	end

	pds_front #(.MAX_TERMS(MAX_TERMS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.delta_mode (delta_mode_q),
		.max_error  (max_error_q),
		.fifo_full  (fifo_full),
		.push       (fifo_push),
		.push_data  (push_data),
		.buf_wr     (buf_wr),
		.back_stat  (back_stat)
	);

	pds_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty)
	);

	pds_back #(.MAX_TERMS(MAX_TERMS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.pop_data   (pop_data),
		.pop        (fifo_pop),
		.buf_wr     (buf_wr),
		.stat       (back_stat),
		.result     (result)
	);

`ifndef SYNTH
	// The front end must never overrun the job queue.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("job pushed into a full queue");

	// Buffers must not be rewritten while the back end drains them.
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr.en |-> !back_stat.draining)
		else $error("buffer write during drain");

	// Nothing can be queued behind a drain, so the queue is empty when it ends.
	a_drain_alone: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.drain_done |-> fifo_empty)
		else $error("job queued behind a drain");
`endif

endmodule
